FILE: src/ppa_pkg.sv
// shared types and constants for the pixel pair arithmetic block
package ppa_pkg;

    localparam int ChW       = 8;
    localparam int NumCh     = 3;
    localparam int DivBits   = 4;
    localparam int QuoW      = 16;
    localparam int DivStages = QuoW / DivBits;
    localparam int NumStages = DivStages + 3;
    localparam int CfgW      = 18;
    localparam int CfgIdxW   = 2;

    localparam logic [ChW-1:0] ChMax = 8'd255;
    localparam logic signed [41:0] ClampMax = 42'sd16711680;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3
    } ppa_op_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OP_MODE = 2'd0,
        REG_SCALE   = 2'd1,
        REG_OFFSET  = 2'd2
    } ppa_reg_t;

    typedef struct packed {
        logic [2:0]         op_mode;
        logic signed [15:0] scale_q8;
        logic signed [17:0] offset_q8;
    } ppa_cfg_t;

    typedef struct packed {
        logic [ChW-1:0]  rem;
        logic [QuoW-1:0] num;
        logic [QuoW-1:0] quo;
    } ppa_div_t;

endpackage

FILE: src/ppa_div_stage.sv
// one stage of the restoring divider, DivBits (4) quotient bits per stage
module ppa_div_stage
    import ppa_pkg::*;
(
    input  logic [ChW-1:0] divisor,
    input  ppa_div_t       div_in,
    output ppa_div_t       div_out
);

    logic [ChW:0] trial;
    ppa_div_t     work;

    always_comb begin
        work  = div_in;
        trial = '0;
        for (int i = 0; i < DivBits; i++) begin
            trial    = {work.rem, work.num[QuoW-1]};
            work.num = {work.num[QuoW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                work.rem = ChW'(trial - {1'b0, divisor});
                work.quo = {work.quo[QuoW-2:0], 1'b1};
            end else begin
                work.rem = trial[ChW-1:0];
                work.quo = {work.quo[QuoW-2:0], 1'b0};
            end
        end
        div_out = work;
    end

endmodule

FILE: src/ppa_channel.sv
// datapath of one color channel: op, divide, scale, offset, clamp and round
module ppa_channel
    import ppa_pkg::*;
(
    input  logic                 aclk,
    input  logic [NumStages-1:0] en,
    input  ppa_cfg_t             cfg,
    input  logic [ChW-1:0]       a_in,
    input  logic [ChW-1:0]       b_in,
    output logic [ChW-1:0]       out_ch
);

    ppa_div_t              div_reg  [DivStages];
    ppa_div_t              div_next [DivStages];
    logic [ChW-1:0]        b_reg    [DivStages];
    logic signed [16:0]    n_reg    [DivStages];
    logic                  dz_reg   [NumStages-1];
    logic [ChW-1:0]        spec_reg [NumStages-1];

    logic signed [16:0]    n_next;
    logic                  dz_next;
    logic [ChW-1:0]        spec_next;
    ppa_div_t              div_init;

    logic signed [16:0]    mul_op;
    logic signed [32:0]    prod_reg, prod_next;
    logic signed [25:0]    off_sel;
    logic signed [33:0]    sum_lo;
    logic signed [41:0]    acc_reg, acc_next;
    logic                  rnd_up;
    logic [ChW-1:0]        out_reg, out_next;

    // stage 0 front end
    always_comb begin
        unique case (cfg.op_mode)
            OP_ADD:  n_next = {9'd0, a_in} + {9'd0, b_in};
            OP_SUB:  n_next = {9'd0, a_in} - {9'd0, b_in};
            OP_MUL:  n_next = {1'b0, 16'(a_in) * 16'(b_in)};
            default: n_next = '0;
        endcase
        dz_next   = (cfg.op_mode == OP_DIV) && (b_in == '0);
        spec_next = ((a_in != '0) && cfg.scale_q8[15]) ? '0 : ChMax;
        div_init  = '{rem: '0, num: {a_in, 8'd0}, quo: '0};
    end

    for (genvar k = 0; k < DivStages; k++) begin : g_div
        if (k == 0) begin : g_first
            ppa_div_stage u_div (
                .divisor (b_in),
                .div_in  (div_init),
                .div_out (div_next[k])
            );
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    div_reg[k] <= div_next[k];
                    b_reg[k]   <= b_in;
                    n_reg[k]   <= n_next;
                end
            end
        end else begin : g_rest
            ppa_div_stage u_div (
                .divisor (b_reg[k-1]),
                .div_in  (div_reg[k-1]),
                .div_out (div_next[k])
            );
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    div_reg[k] <= div_next[k];
                    b_reg[k]   <= b_reg[k-1];
                    n_reg[k]   <= n_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < NumStages - 1; k++) begin : g_flag
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    dz_reg[k]   <= dz_next;
                    spec_reg[k] <= spec_next;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    dz_reg[k]   <= dz_reg[k-1];
                    spec_reg[k] <= spec_reg[k-1];
                end
            end
        end
    end

    // scale
    always_comb begin
        mul_op    = (cfg.op_mode == OP_DIV) ? $signed({1'b0, div_reg[DivStages-1].quo})
                                            : n_reg[DivStages-1];
        prod_next = 33'(mul_op) * 33'(cfg.scale_q8);
    end

    // offset, aligned to 16 fraction bits
    always_comb begin
        off_sel  = (cfg.op_mode == OP_DIV) ? (26'(cfg.offset_q8) <<< 8) : 26'(cfg.offset_q8);
        sum_lo   = 34'(prod_reg) + 34'(off_sel);
        acc_next = (cfg.op_mode == OP_DIV) ? 42'(sum_lo) : (42'(sum_lo) <<< 8);
    end

    // clamp and round half to even
    always_comb begin
        rnd_up = (acc_reg[15:0] > 16'h8000) || ((acc_reg[15:0] == 16'h8000) && acc_reg[16]);
        if (dz_reg[NumStages-2]) begin
            out_next = spec_reg[NumStages-2];
        end else if (acc_reg[41]) begin
            out_next = '0;
        end else if (acc_reg > ClampMax) begin
            out_next = ChMax;
        end else begin
            out_next = acc_reg[23:16] + ChW'(rnd_up);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DivStages]) begin
            prod_reg <= prod_next;
        end
        if (en[DivStages+1]) begin
            acc_reg <= acc_next;
        end
        if (en[DivStages+2]) begin
            out_reg <= out_next;
        end
    end

    assign out_ch = out_reg;

endmodule

FILE: src/pixel_pair_arithmetic_top.sv
// pixel pair arithmetic: top level with config registers and pipeline control
//
// input stream s_*: one pixel pair per transaction, three 8-bit channels of
// each pixel in s_tdata. output stream m_*: one result pixel per transaction.
// per channel the result is (a op b) * scale + offset, clamped to 0..255 and
// rounded half to even; op is add, subtract, multiply, divide or zero.
// config port: cfg_we writes cfg_wdata into register cfg_index
// (0 op_mode, 1 scale_q8, 2 offset_q8); write only while the pipeline is empty.
// the pipeline is the four-stage divider (4 quotient bits a stage) plus
// scale, offset and round stages; throughput is one transaction per cycle
// while m_tready does not stall the pipeline.
// each stage holds a valid bit and loads when it is empty or the next stage
// moves, so a stall of m_tready fills the bubbles and then drops s_tready;
// nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the pipeline and loads
// op_mode 0, scale 1.0 and offset 0.
module pixel_pair_arithmetic_top
    import ppa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // a_ch0, a_ch1, a_ch2, b_ch0, b_ch1, b_ch2
    input  logic [47:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_ch0, out_ch1, out_ch2
    output logic [23:0]        m_tdata,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata
);

    ppa_cfg_t             cfg_reg;
    logic [NumStages-1:0] vld_reg, vld_next;
    logic [NumStages-1:0] en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op_mode   <= OP_ADD;
            cfg_reg.scale_q8  <= 16'sd256;
            cfg_reg.offset_q8 <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OP_MODE: cfg_reg.op_mode   <= cfg_wdata[2:0];
                REG_SCALE:   cfg_reg.scale_q8  <= cfg_wdata[15:0];
                REG_OFFSET:  cfg_reg.offset_q8 <= cfg_wdata;
                default:     cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        en[NumStages-1] = !vld_reg[NumStages-1] || m_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        for (int k = 0; k < NumStages; k++) begin
            if (en[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    for (genvar c = 0; c < NumCh; c++) begin : g_ch
        ppa_channel u_ch (
            .aclk   (aclk),
            .en     (en),
            .cfg    (cfg_reg),
            .a_in   (s_tdata[c*ChW +: ChW]),
            .b_in   (s_tdata[(c+NumCh)*ChW +: ChW]),
            .out_ch (m_tdata[c*ChW +: ChW])
        );
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NumStages-1];

endmodule

FILE: src/ppa_checker.sv
// port-level checker for the pixel pair arithmetic block and its bind
module ppa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // a moving output never blocks the input
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

endmodule

bind pixel_pair_arithmetic_top ppa_checker u_ppa_checker (.*);
